// ----- rtl/lpp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar point projection package
// Shared widths, register indexes and pipeline stage counts.
// ----------------------------------------------------------------------------
package lpp_pkg;

  localparam int PointW    = 24;
  localparam int RotW      = 18;
  localparam int TransW    = 20;
  localparam int CamW      = 29;
  localparam int NormW     = 28;
  localparam int NormShift = 24;
  localparam int DivQBits  = 27;
  localparam logic [DivQBits-1:0] NormLimit = 27'd67108864;

  localparam int SqrtInW  = 48;
  localparam int SqrtBits = 24;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegRot0     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRot1     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRot2     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTrans    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFocal    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPrincpal = 3'd5;
  localparam logic [CfgIdxW-1:0] RegRadial   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegTangent  = 3'd7;

  localparam int DivLat    = DivQBits + 2;
  localparam int SqrtLat   = SqrtBits;
  localparam int StageCam  = 2;
  localparam int PixRegs   = 10;
  localparam int StagePix  = StageCam + DivLat + PixRegs;
  localparam int StageFrac = StageCam + SqrtLat + 3;
  localparam int ColorRegs = StagePix - StageFrac;
  localparam int BehRegs   = StagePix - StageCam;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

// ----- rtl/lpp_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined normalizing divider
// Computes num * 2^24 / den truncated toward zero and saturated to +-4.0,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module lpp_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic signed [lpp_pkg::CamW-1:0]  num_i,
  input  logic signed [lpp_pkg::CamW-1:0]  den_i,
  output logic                             valid_o,
  output logic signed [lpp_pkg::NormW-1:0] quot_o
);

  localparam int QB   = lpp_pkg::DivQBits;
  localparam int DenW = lpp_pkg::CamW - 1;
  localparam int RemW = DenW + QB;

  logic [RemW-1:0] rem_q [QB];
  logic [DenW-1:0] den_q [QB];
  logic [QB-1:0]   quo_q [QB+1];
  logic            neg_q [QB+1];
  logic            ovf_q [QB+1];
  logic            vld_q [QB+1];

  logic [lpp_pkg::CamW-1:0] mag;
  logic [QB-1:0]            qmag;
  logic                     out_vld_q;
  logic signed [lpp_pkg::NormW-1:0] quot_q;

  assign mag = num_i[lpp_pkg::CamW-1] ? lpp_pkg::CamW'(-num_i) : lpp_pkg::CamW'(num_i);

  always_ff @(posedge clk_i) begin
    rem_q[0] <= RemW'({mag, {lpp_pkg::NormShift{1'b0}}});
    den_q[0] <= den_i[DenW-1:0];
    quo_q[0] <= '0;
    neg_q[0] <= num_i[lpp_pkg::CamW-1];
    ovf_q[0] <= (DenW+3)'(mag) >= {den_i[DenW-1:0], 3'b000};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [RemW-1:0] trial;
    logic            take;

    assign trial = RemW'(den_q[k]) << (QB - 1 - k);
    assign take  = rem_q[k] >= trial;

    always_ff @(posedge clk_i) begin
      quo_q[k+1] <= {quo_q[k][QB-2:0], take};
      neg_q[k+1] <= neg_q[k];
      ovf_q[k+1] <= ovf_q[k];
    end

    if (k < QB - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[k+1] <= take ? rem_q[k] - trial : rem_q[k];
        den_q[k+1] <= den_q[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  assign qmag = (ovf_q[QB] || quo_q[QB] > lpp_pkg::NormLimit) ? lpp_pkg::NormLimit : quo_q[QB];

  always_ff @(posedge clk_i) begin
    quot_q <= neg_q[QB] ? -$signed(lpp_pkg::NormW'(qmag)) : $signed(lpp_pkg::NormW'(qmag));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[QB];
    end
  end

  assign valid_o = out_vld_q;
  assign quot_o  = quot_q;

endmodule

// ----- rtl/lpp_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 48-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module lpp_sqrt (
  input  logic                               clk_i,
  input  logic [lpp_pkg::SqrtInW-1:0]        rad_i,
  output logic [lpp_pkg::SqrtBits-1:0]       root_o
);

  localparam int SB = lpp_pkg::SqrtBits;
  localparam int VW = lpp_pkg::SqrtInW;
  localparam int RW = VW + 1;

  logic [VW-1:0] v_q   [SB-1];
  logic [RW-1:0] r_q   [SB];

  for (genvar k = 0; k < SB; k++) begin : g_stage
    logic [VW-1:0] vin;
    logic [RW-1:0] rin;
    logic [RW-1:0] bitv;
    logic [RW-1:0] sum;
    logic          take;

    if (k == 0) begin : g_first
      assign vin = rad_i;
      assign rin = '0;
    end else begin : g_next
      assign vin = v_q[k-1];
      assign rin = r_q[k-1];
    end

    assign bitv = RW'(1) << (2 * (SB - 1 - k));
    assign sum  = rin + bitv;
    assign take = RW'(vin) >= sum;

    always_ff @(posedge clk_i) begin
      r_q[k] <= take ? (rin >> 1) + bitv : rin >> 1;
    end

    if (k < SB - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        v_q[k] <= take ? vin - sum[VW-1:0] : vin;
      end
    end
  end

  assign root_o = r_q[SB-1][SB-1:0];

endmodule

// ----- rtl/lidar_point_projection.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar point projection
// Rotates and translates a lidar point into the camera frame, projects it
// through a lens model with radial and tangential distortion to a pixel, and
// colors it by range along a six-segment hue ramp.
//
//   Channel   Handshake          Payload
//   --------  -----------------  ----------------------------------------------
//   point     start / busy       point_x_i, point_y_i, point_z_i
//   result    done_o strobe      pixel_u_o, pixel_v_o, behind_camera_o, color_*
//   config    cfg_we_i           cfg_idx_i, cfg_data_i
//
// One point word is taken every clock; busy stays low.
// The pipeline depth from point to result is set mostly by the 27 quotient
// stages of the perspective divider.
// Reset clears all valid bits and restores the identity rotation.
// The result strobe lasts one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module lidar_point_projection (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [lpp_pkg::PointW-1:0]   point_x_i,
  input  logic signed [lpp_pkg::PointW-1:0]   point_y_i,
  input  logic signed [lpp_pkg::PointW-1:0]   point_z_i,
  input  logic                                cfg_we_i,
  input  logic [lpp_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [lpp_pkg::CfgDataW-1:0]        cfg_data_i,
  output logic                                done_o,
  output logic signed [15:0]                  pixel_u_o,
  output logic signed [15:0]                  pixel_v_o,
  output logic                                behind_camera_o,
  output logic [7:0]                          color_red_o,
  output logic [7:0]                          color_green_o,
  output logic [7:0]                          color_blue_o
);

  localparam logic [2:0] SegGreenUp   = 3'd0;
  localparam logic [2:0] SegRedDown   = 3'd1;
  localparam logic [2:0] SegBlueUp    = 3'd2;
  localparam logic [2:0] SegGreenDown = 3'd3;
  localparam logic [2:0] SegRedUp     = 3'd4;
  localparam logic [2:0] SegBlueDown  = 3'd5;

  localparam logic [31:0] RecipFive = 32'hCCCCCCCD;

  localparam int PW = lpp_pkg::PointW;
  localparam int CW = lpp_pkg::CamW;
  localparam int NW = lpp_pkg::NormW;

  // Configuration registers.
  logic [53:0] rot_q [3];
  logic [59:0] trans_q;
  logic [63:0] focal_q, princ_q, radc_q, tanc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0] <= 54'd65536;
      rot_q[1] <= 54'd17179869184;
      rot_q[2] <= 54'd4503599627370496;
      trans_q  <= '0;
      focal_q  <= '0;
      princ_q  <= '0;
      radc_q   <= '0;
      tanc_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lpp_pkg::RegRot0:     rot_q[0] <= cfg_data_i[53:0];
        lpp_pkg::RegRot1:     rot_q[1] <= cfg_data_i[53:0];
        lpp_pkg::RegRot2:     rot_q[2] <= cfg_data_i[53:0];
        lpp_pkg::RegTrans:    trans_q  <= cfg_data_i[59:0];
        lpp_pkg::RegFocal:    focal_q  <= cfg_data_i;
        lpp_pkg::RegPrincpal: princ_q  <= cfg_data_i;
        lpp_pkg::RegRadial:   radc_q   <= cfg_data_i;
        lpp_pkg::RegTangent:  tanc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: rotation products and point squares.
  logic signed [PW-1:0]   pt [3];
  logic signed [41:0]     prod_d [3][3];
  logic signed [41:0]     prod_q [3][3];
  logic signed [2*PW-1:0] sqs_d [3];
  logic [2*PW-1:0]        sq_q [3];
  logic                   v1_q;

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] = $signed(rot_q[i][lpp_pkg::RotW*j +: lpp_pkg::RotW]) * pt[j];
      end
      sqs_d[i] = pt[i] * pt[i];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= unsigned'(sqs_d[i]);
    end
  end

  // Stage 2: camera coordinates and squared range.
  logic signed [43:0]   rsum [3];
  logic signed [CW-1:0] cam_d [3];
  logic signed [CW-1:0] cam_q [3];
  logic [2*PW-1:0]      d2_q;
  logic                 v2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum[i] = 44'(prod_q[i][0]) + 44'(prod_q[i][1]) + 44'(prod_q[i][2]);
      cam_d[i] = CW'(rsum[i] >>> 16)
               + CW'($signed(trans_q[lpp_pkg::TransW*i +: lpp_pkg::TransW]));
    end
  end

  always_ff @(posedge clk_i) begin
    cam_q <= cam_d;
    d2_q  <= sq_q[0] + sq_q[1] + sq_q[2];
  end

  // Perspective divide.
  logic signed [NW-1:0] xn_w, yn_w;
  logic                 nvld_w, nvld_y_w;

  lpp_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .num_i   (cam_q[0]),
    .den_i   (cam_q[2]),
    .valid_o (nvld_w),
    .quot_o  (xn_w)
  );

  lpp_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .num_i   (cam_q[1]),
    .den_i   (cam_q[2]),
    .valid_o (nvld_y_w),
    .quot_o  (yn_w)
  );

  // Lens distortion.
  logic signed [31:0] k1, k2, p1, p2;
  assign k1 = $signed(radc_q[31:0]);
  assign k2 = $signed(radc_q[63:32]);
  assign p1 = $signed(tanc_q[31:0]);
  assign p2 = $signed(tanc_q[63:32]);

  logic signed [55:0]   xx_q, yy_q, xy_q;
  logic signed [NW-1:0] xn1_q, yn1_q;
  logic signed [30:0]   r2_q;
  logic signed [29:0]   x2_q, y2_q, xys_q;
  logic signed [NW-1:0] xn2_q, yn2_q;
  logic signed [61:0]   r4p_q, p1xy_q, p2xy_q;
  logic signed [62:0]   k1r2_q;
  logic signed [31:0]   sx_q, sy_q;
  logic signed [NW-1:0] xn3_q, yn3_q;
  logic signed [37:0]   r4_q;
  logic signed [38:0]   k1t_q, tax_q, tay_q;
  logic signed [63:0]   tbxp_q, tbyp_q;
  logic signed [NW-1:0] xn4_q, yn4_q;
  logic signed [29:0]   r4s;
  logic signed [61:0]   k2r4_q;
  logic signed [38:0]   k1t5_q;
  logic signed [40:0]   tanx_q, tany_q;
  logic signed [NW-1:0] xn5_q, yn5_q;
  logic signed [47:0]   radf;
  logic signed [31:0]   rad_d, rad_q;
  logic signed [40:0]   tanx6_q, tany6_q;
  logic signed [NW-1:0] xn6_q, yn6_q;
  logic signed [59:0]   xr_q, yr_q;
  logic signed [40:0]   tanx7_q, tany7_q;
  logic signed [41:0]   xdf, ydf;
  logic signed [31:0]   xd_d, yd_d, xd_q, yd_q;
  logic signed [64:0]   up_q, vp_q;
  logic signed [41:0]   pu_q, pv_q;

  assign r4s = 30'(r4_q >>> 8);

  always_comb begin
    radf = 48'sd16777216 + 48'(k1t5_q) + 48'(k2r4_q >>> 16);
    if (radf > 48'sd2147483647) begin
      rad_d = 32'sh7FFFFFFF;
    end else if (radf < -48'sd2147483648) begin
      rad_d = 32'sh80000000;
    end else begin
      rad_d = radf[31:0];
    end
    xdf = 42'(xr_q >>> 24) + 42'(tanx7_q);
    ydf = 42'(yr_q >>> 24) + 42'(tany7_q);
    if (xdf > 42'sd1073741824) begin
      xd_d = 32'sd1073741824;
    end else if (xdf < -42'sd1073741824) begin
      xd_d = -32'sd1073741824;
    end else begin
      xd_d = xdf[31:0];
    end
    if (ydf > 42'sd1073741824) begin
      yd_d = 32'sd1073741824;
    end else if (ydf < -42'sd1073741824) begin
      yd_d = -32'sd1073741824;
    end else begin
      yd_d = ydf[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    xx_q    <= xn_w * xn_w;
    yy_q    <= yn_w * yn_w;
    xy_q    <= xn_w * yn_w;
    xn1_q   <= xn_w;
    yn1_q   <= yn_w;

    r2_q    <= 31'((xx_q + yy_q) >>> 24);
    x2_q    <= 30'(xx_q >>> 24);
    y2_q    <= 30'(yy_q >>> 24);
    xys_q   <= 30'(xy_q >>> 24);
    xn2_q   <= xn1_q;
    yn2_q   <= yn1_q;

    r4p_q   <= r2_q * r2_q;
    k1r2_q  <= k1 * r2_q;
    sx_q    <= 32'(r2_q) + (32'(x2_q) <<< 1);
    sy_q    <= 32'(r2_q) + (32'(y2_q) <<< 1);
    p1xy_q  <= p1 * xys_q;
    p2xy_q  <= p2 * xys_q;
    xn3_q   <= xn2_q;
    yn3_q   <= yn2_q;

    r4_q    <= 38'(r4p_q >>> 24);
    k1t_q   <= 39'(k1r2_q >>> 24);
    tax_q   <= 39'(p1xy_q >>> 23);
    tay_q   <= 39'(p2xy_q >>> 23);
    tbxp_q  <= p2 * sx_q;
    tbyp_q  <= p1 * sy_q;
    xn4_q   <= xn3_q;
    yn4_q   <= yn3_q;

    k2r4_q  <= k2 * r4s;
    k1t5_q  <= k1t_q;
    tanx_q  <= 41'(tax_q) + 41'(tbxp_q >>> 24);
    tany_q  <= 41'(tay_q) + 41'(tbyp_q >>> 24);
    xn5_q   <= xn4_q;
    yn5_q   <= yn4_q;

    rad_q   <= rad_d;
    tanx6_q <= tanx_q;
    tany6_q <= tany_q;
    xn6_q   <= xn5_q;
    yn6_q   <= yn5_q;

    xr_q    <= xn6_q * rad_q;
    yr_q    <= yn6_q * rad_q;
    tanx7_q <= tanx6_q;
    tany7_q <= tany6_q;

    xd_q    <= xd_d;
    yd_q    <= yd_d;

    up_q    <= $signed({1'b0, focal_q[31:0]}) * xd_q;
    vp_q    <= $signed({1'b0, focal_q[63:32]}) * yd_q;

    pu_q    <= 42'(up_q >>> 24) + 42'($signed({1'b0, princ_q[31:0]}));
    pv_q    <= 42'(vp_q >>> 24) + 42'($signed({1'b0, princ_q[63:32]}));
  end

  // Range color.
  logic [lpp_pkg::SqrtBits-1:0] root_w;

  lpp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rad_i   (d2_q),
    .root_o  (root_w)
  );

  logic [25:0] n3_q;
  logic [57:0] cprod;
  logic [23:0] c_q;
  logic [2:0]  seg_d, seg_q;
  logic [12:0] frac_d, frac_q;
  logic [7:0]  rmp;
  lpp_pkg::rgb_t col_d;
  lpp_pkg::rgb_t col_q [lpp_pkg::ColorRegs];

  assign cprod = 58'(n3_q) * 58'(RecipFive);
  assign rmp   = 8'((21'(frac_q) * 21'd255) >> 12);

  always_comb begin
    if (c_q <= 24'd4096) begin
      seg_d  = SegGreenUp;
      frac_d = c_q[12:0];
    end else if (c_q <= 24'd8192) begin
      seg_d  = SegRedDown;
      frac_d = 13'(24'd8192 - c_q);
    end else if (c_q <= 24'd12288) begin
      seg_d  = SegBlueUp;
      frac_d = 13'(c_q - 24'd8192);
    end else if (c_q <= 24'd16384) begin
      seg_d  = SegGreenDown;
      frac_d = 13'(24'd16384 - c_q);
    end else if (c_q <= 24'd20480) begin
      seg_d  = SegRedUp;
      frac_d = 13'(c_q - 24'd16384);
    end else begin
      seg_d  = SegBlueDown;
      frac_d = (c_q < 24'd24576) ? 13'(24'd24576 - c_q) : 13'd0;
    end
  end

  always_comb begin
    case (seg_q)
      SegGreenUp:   col_d = '{red: 8'd255, green: rmp,    blue: 8'd0};
      SegRedDown:   col_d = '{red: rmp,    green: 8'd255, blue: 8'd0};
      SegBlueUp:    col_d = '{red: 8'd0,   green: 8'd255, blue: rmp};
      SegGreenDown: col_d = '{red: 8'd0,   green: rmp,    blue: 8'd255};
      SegRedUp:     col_d = '{red: rmp,    green: 8'd0,   blue: 8'd255};
      default:      col_d = '{red: 8'd255, green: 8'd0,   blue: rmp};
    endcase
  end

  always_ff @(posedge clk_i) begin
    n3_q     <= 26'({root_w, 1'b0}) + 26'(root_w);
    c_q      <= cprod[57:34];
    seg_q    <= seg_d;
    frac_q   <= frac_d;
    col_q[0] <= col_d;
    for (int k = 1; k < lpp_pkg::ColorRegs; k++) begin
      col_q[k] <= col_q[k-1];
    end
  end

  // Behind-camera flag travels alongside the projection.
  logic beh_q [lpp_pkg::BehRegs];

  always_ff @(posedge clk_i) begin
    beh_q[0] <= cam_q[2][CW-1] || (cam_q[2] == '0);
    for (int k = 1; k < lpp_pkg::BehRegs; k++) begin
      beh_q[k] <= beh_q[k-1];
    end
  end

  // Valid chain.
  logic vpipe_q [lpp_pkg::PixRegs];
  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
      for (int k = 0; k < lpp_pkg::PixRegs; k++) begin
        vpipe_q[k] <= 1'b0;
      end
    end else begin
      v1_q       <= start;
      v2_q       <= v1_q;
      vpipe_q[0] <= nvld_w && nvld_y_w;
      for (int k = 1; k < lpp_pkg::PixRegs; k++) begin
        vpipe_q[k] <= vpipe_q[k-1];
      end
      done_q <= vpipe_q[lpp_pkg::PixRegs-1];
    end
  end

  // Output stage.
  function automatic logic [15:0] to_pix(input logic signed [41:0] p);
    logic [41:0] mag;
    logic [25:0] ip;
    logic [15:0] res;
    mag = p[41] ? 42'(-p) : 42'(p);
    ip  = mag[41:16];
    if (!p[41]) begin
      res = (ip > 26'd32767) ? 16'h7FFF : ip[15:0];
    end else begin
      res = (ip > 26'd32768) ? 16'h8000 : 16'(-ip[15:0]);
    end
    return res;
  endfunction

  logic signed [15:0] pixel_u_q, pixel_v_q;
  logic               behind_q;
  lpp_pkg::rgb_t      color_q;

  always_ff @(posedge clk_i) begin
    behind_q  <= beh_q[lpp_pkg::BehRegs-1];
    pixel_u_q <= beh_q[lpp_pkg::BehRegs-1] ? 16'sd0 : $signed(to_pix(pu_q));
    pixel_v_q <= beh_q[lpp_pkg::BehRegs-1] ? 16'sd0 : $signed(to_pix(pv_q));
    color_q   <= col_q[lpp_pkg::ColorRegs-1];
  end

  assign done_o          = done_q;
  assign pixel_u_o       = pixel_u_q;
  assign pixel_v_o       = pixel_v_q;
  assign behind_camera_o = behind_q;
  assign color_red_o     = color_q.red;
  assign color_green_o   = color_q.green;
  assign color_blue_o    = color_q.blue;

endmodule

// ----- tb/lidar_point_projection_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar point projection testbench
// Drives point words through the start/busy port, with random gaps in all
// phases but the last, and checks every result word, field by field, against
// a cycle-free model of the camera projection, lens distortion and range color
// ramp. Configuration is changed between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module lidar_point_projection_tb;

  typedef struct {
    logic signed [lpp_pkg::PointW-1:0] x;
    logic signed [lpp_pkg::PointW-1:0] y;
    logic signed [lpp_pkg::PointW-1:0] z;
  } point_t;

  typedef struct {
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic               behind;
    lpp_pkg::rgb_t      color;
  } pixel_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              start;
  logic                              busy;
  logic signed [lpp_pkg::PointW-1:0] point_x_i;
  logic signed [lpp_pkg::PointW-1:0] point_y_i;
  logic signed [lpp_pkg::PointW-1:0] point_z_i;
  logic                              cfg_we_i;
  logic [lpp_pkg::CfgIdxW-1:0]       cfg_idx_i;
  logic [lpp_pkg::CfgDataW-1:0]      cfg_data_i;
  logic                              done_o;
  logic signed [15:0]                pixel_u_o;
  logic signed [15:0]                pixel_v_o;
  logic                              behind_camera_o;
  logic [7:0]                        color_red_o;
  logic [7:0]                        color_green_o;
  logic [7:0]                        color_blue_o;

  lidar_point_projection u_dut (
    .clk_i, .rst_ni, .start, .busy, .point_x_i, .point_y_i, .point_z_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .done_o, .pixel_u_o, .pixel_v_o,
    .behind_camera_o, .color_red_o, .color_green_o, .color_blue_o
  );

  logic [63:0] cam_regs [8];
  point_t      point_q[$];
  pixel_t      pixel_q[$];
  int          gap_left;
  bit          gaps_on;
  bit          failed;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint sx(logic [63:0] v, int w);
    longint t;
    t = v;
    t = t <<< (64 - w);
    return t >>> (64 - w);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint bend(longint a, longint xy, longint r2, longint rad,
                                  longint pa, longint pb);
    longint a2, d;
    a2 = (a * a) >>> 24;
    d = ((a * rad) >>> 24) + ((2 * pa * xy) >>> 24) + ((pb * (r2 + 2 * a2)) >>> 24);
    return clip(d, -(64'sd1 <<< 30), 64'sd1 <<< 30);
  endfunction

  function automatic logic [15:0] to_pix(logic [31:0] f, logic [31:0] c, longint d);
    longint fl, p, i;
    fl = longint'({32'd0, f});
    p = ((fl * d) >>> 24) + longint'({32'd0, c});
    i = p >= 0 ? (p >>> 16) : -((-p) >>> 16);
    return 16'(clip(i, -32768, 32767));
  endfunction

  function automatic logic [7:0] shade(longint frac);
    return 8'((frac * 255) >>> 12);
  endfunction

  function automatic pixel_t project(point_t pt);
    pixel_t res;
    longint p[3], cam[3], s, xn, yn, r2, r4, xy, k1, k2, p1, p2, rad, xd, yd, c;
    longint unsigned d2;
    p[0] = pt.x;
    p[1] = pt.y;
    p[2] = pt.z;
    for (int i = 0; i < 3; i++) begin
      s = 0;
      for (int j = 0; j < 3; j++) s += sx(cam_regs[i] >> (18 * j), 18) * p[j];
      cam[i] = (s >>> 16) + sx(cam_regs[lpp_pkg::RegTrans] >> (20 * i), 20);
    end
    if (cam[2] <= 0) begin
      res.u = '0;
      res.v = '0;
      res.behind = 1'b1;
    end else begin
      xn = clip((cam[0] <<< 24) / cam[2], -(64'sd1 <<< 26), 64'sd1 <<< 26);
      yn = clip((cam[1] <<< 24) / cam[2], -(64'sd1 <<< 26), 64'sd1 <<< 26);
      r2 = (xn * xn + yn * yn) >>> 24;
      r4 = (r2 * r2) >>> 24;
      xy = (xn * yn) >>> 24;
      k1 = sx(cam_regs[lpp_pkg::RegRadial], 32);
      k2 = sx(cam_regs[lpp_pkg::RegRadial] >> 32, 32);
      p1 = sx(cam_regs[lpp_pkg::RegTangent], 32);
      p2 = sx(cam_regs[lpp_pkg::RegTangent] >> 32, 32);
      rad = (64'sd1 <<< 24) + ((k1 * r2) >>> 24) + ((k2 * (r4 >>> 8)) >>> 16);
      rad = clip(rad, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
      xd = bend(xn, xy, r2, rad, p1, p2);
      yd = bend(yn, xy, r2, rad, p2, p1);
      res.u = to_pix(cam_regs[lpp_pkg::RegFocal][31:0],
                     cam_regs[lpp_pkg::RegPrincpal][31:0], xd);
      res.v = to_pix(cam_regs[lpp_pkg::RegFocal][63:32],
                     cam_regs[lpp_pkg::RegPrincpal][63:32], yd);
      res.behind = 1'b0;
    end
    d2 = 0;
    for (int i = 0; i < 3; i++) d2 += longint'(p[i] * p[i]);
    c = (int_sqrt(d2) * 6) / 10;
    if (c <= 4096) begin
      res.color = '{8'd255, shade(c), 8'd0};
    end else if (c <= 8192) begin
      res.color = '{shade(8192 - c), 8'd255, 8'd0};
    end else if (c <= 12288) begin
      res.color = '{8'd0, 8'd255, shade(c - 8192)};
    end else if (c <= 16384) begin
      res.color = '{8'd0, shade(16384 - c), 8'd255};
    end else if (c <= 20480) begin
      res.color = '{shade(c - 16384), 8'd0, 8'd255};
    end else begin
      res.color = '{8'd255, 8'd0, c < 24576 ? shade(24576 - c) : 8'd0};
    end
    return res;
  endfunction

  // Driver: a word is taken at an edge where start is high and busy is low.
  always @(posedge clk_i or negedge rst_ni) begin
    point_t pt;
    if (!rst_ni) begin
      start     <= 1'b0;
      point_x_i <= '0;
      point_y_i <= '0;
      point_z_i <= '0;
      gap_left  = 0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else begin
      if (start) begin
        pt.x = point_x_i;
        pt.y = point_y_i;
        pt.z = point_z_i;
        pixel_q = {pixel_q, project(pt)};
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        gap_left = int'($urandom_range(1, 17)) - 1;
        start <= 1'b0;
      end else if (point_q.size() > 0) begin
        pt = point_q.pop_front();
        point_x_i <= pt.x;
        point_y_i <= pt.y;
        point_z_i <= pt.z;
        start     <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && done_o) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected result word u=%0d v=%0d", $time, pixel_u_o, pixel_v_o);
        failed = 1'b1;
      end else begin
        want = pixel_q.pop_front();
        if (pixel_u_o !== want.u) begin
          $display("%0t: pixel_u expected %0d actual %0d", $time, want.u, pixel_u_o);
          failed = 1'b1;
        end
        if (pixel_v_o !== want.v) begin
          $display("%0t: pixel_v expected %0d actual %0d", $time, want.v, pixel_v_o);
          failed = 1'b1;
        end
        if (behind_camera_o !== want.behind) begin
          $display("%0t: behind_camera expected %0b actual %0b", $time, want.behind,
                   behind_camera_o);
          failed = 1'b1;
        end
        if (color_red_o !== want.color.red) begin
          $display("%0t: red expected %0d actual %0d", $time, want.color.red, color_red_o);
          failed = 1'b1;
        end
        if (color_green_o !== want.color.green) begin
          $display("%0t: green expected %0d actual %0d", $time, want.color.green,
                   color_green_o);
          failed = 1'b1;
        end
        if (color_blue_o !== want.color.blue) begin
          $display("%0t: blue expected %0d actual %0d", $time, want.color.blue,
                   color_blue_o);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic write_reg(logic [lpp_pkg::CfgIdxW-1:0] idx, logic [63:0] data);
    logic [63:0] mask;
    mask = (idx <= lpp_pkg::RegRot2) ? {10'd0, {54{1'b1}}} :
           (idx == lpp_pkg::RegTrans) ? {4'd0, {60{1'b1}}} : {64{1'b1}};
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    cam_regs[idx] = data & mask;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (point_q.size() > 0 || start || pixel_q.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic add_point(longint x, longint y, longint z);
    point_t pt;
    pt.x = lpp_pkg::PointW'(x);
    pt.y = lpp_pkg::PointW'(y);
    pt.z = lpp_pkg::PointW'(z);
    point_q = {point_q, pt};
  endtask

  function automatic longint coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return longint'($urandom_range(0, 65536)) - 32768;
    if (sel < 8) return sx({32'd0, $urandom}, lpp_pkg::PointW);
    return longint'($urandom_range(0, 16)) - 8;
  endfunction

  task automatic random_points(int n);
    repeat (n) begin
      if ($urandom_range(0, 3) != 0)
        add_point(coord(), coord(), longint'($urandom_range(1, 60000)));
      else
        add_point(coord(), coord(), coord());
    end
  endtask

  function automatic logic [63:0] rot_row(int r);
    logic [17:0] e [3];
    for (int j = 0; j < 3; j++) e[j] = (j == r) ? 18'h10000 : 18'h0;
    return {10'd0, e[2], e[1], e[0]};
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    gaps_on    = 1'b1;
    failed     = 1'b0;
    cam_regs = '{rot_row(0), rot_row(1), rot_row(2), '0, '0, '0, '0, '0};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_point(0, 0, 0);
    add_point(0, 0, 1);
    add_point(0, 0, -1);
    add_point(8388607, 8388607, 8388607);
    add_point(-8388608, -8388608, -8388608);
    add_point(8388607, -8388608, 1);
    add_point(-8388608, 8388607, 1);
    add_point(6827, 0, 0);
    add_point(13654, 0, 0);
    add_point(0, 20480, 0);
    add_point(0, 0, 27307);
    add_point(34134, 0, 0);
    add_point(0, 0, 40960);
    add_point(0, 0, 45000);
    add_point(4096, 4096, 4096);
    random_points(120);
    drain();

    write_reg(lpp_pkg::RegFocal, {32'd500 << 16, 32'd500 << 16});
    write_reg(lpp_pkg::RegPrincpal, {32'd360 << 16, 32'd640 << 16});
    write_reg(lpp_pkg::RegRadial, {32'hFF80_0000, 32'h0020_0000});
    write_reg(lpp_pkg::RegTangent, {32'h0001_0000, 32'hFFFF_8000});
    write_reg(lpp_pkg::RegTrans, {4'd0, 20'h01000, 20'hFF800, 20'h00400});
    add_point(8388607, 0, 1);
    add_point(-8388608, 0, 1);
    add_point(0, 8388607, 1);
    add_point(1000, -2000, 0);
    random_points(180);
    drain();

    write_reg(lpp_pkg::RegRot0, {10'd0, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF});
    write_reg(lpp_pkg::RegRot1, {10'd0, 18'h20000, 18'h20000, 18'h20000});
    write_reg(lpp_pkg::RegRot2, {10'd0, 18'h1FFFF, 18'h20000, 18'h1FFFF});
    write_reg(lpp_pkg::RegTrans, {4'd0, 20'h7FFFF, 20'h80000, 20'h7FFFF});
    write_reg(lpp_pkg::RegFocal, {64{1'b1}});
    write_reg(lpp_pkg::RegPrincpal, {64{1'b1}});
    write_reg(lpp_pkg::RegRadial, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
    write_reg(lpp_pkg::RegTangent, {32'h8000_0000, 32'h7FFF_FFFF});
    random_points(150);
    drain();

    write_reg(lpp_pkg::RegRadial, {32'h8000_0000, 32'h8000_0000});
    write_reg(lpp_pkg::RegTangent, {32'h7FFF_FFFF, 32'h8000_0000});
    write_reg(lpp_pkg::RegPrincpal, '0);
    random_points(100);
    drain();

    for (int ph = 0; ph < 2; ph++) begin
      for (int r = 0; r < 8; r++) write_reg(r[lpp_pkg::CfgIdxW-1:0], rnd64());
      random_points(100);
      drain();
    end

    cam_regs[lpp_pkg::RegRot0] = '0;
    write_reg(lpp_pkg::RegRot0, rot_row(0));
    write_reg(lpp_pkg::RegRot1, rot_row(1));
    write_reg(lpp_pkg::RegRot2, rot_row(2));
    write_reg(lpp_pkg::RegTrans, '0);
    write_reg(lpp_pkg::RegFocal, {32'd800 << 16, 32'd800 << 16});
    write_reg(lpp_pkg::RegPrincpal, {32'd540 << 16, 32'd960 << 16});
    write_reg(lpp_pkg::RegRadial, {32'h0008_0000, 32'hFFF0_0000});
    write_reg(lpp_pkg::RegTangent, {32'hFFFF_F000, 32'h0000_1000});
    random_points(80);
    drain();
    gaps_on = 1'b0;
    random_points(80);
    drain();

    if (!failed) begin
      $display("PASS lidar_point_projection");
    end else begin
      $display("FAIL lidar_point_projection");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL lidar_point_projection");
    $finish;
  end

endmodule
